@@ hdl/cda_pkg.sv @@
// cda_pkg: shared types, codes and calendar helper functions for the
// calendar date-time adder; depends on nothing
package cda_pkg;

  // operation codes
  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_ADD_SEC  = 3'd1;
  localparam logic [2:0] OP_ADD_MIN  = 3'd2;
  localparam logic [2:0] OP_ADD_HOUR = 3'd3;
  localparam logic [2:0] OP_ADD_DAY  = 3'd4;

  localparam logic [11:0] YEAR_MAX = 12'd4095;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_MAR = 4'd3;
  localparam logic [3:0]  MONTH_OCT = 4'd10;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  // reciprocal constants: 60, 24 and 7 may come out one short and are fixed
  // by one compare, 100 is exact over the year range
  localparam int unsigned RECIP_SHIFT = 16;
  localparam logic [11:0] RECIP_60    = 12'd1092;
  localparam logic [11:0] RECIP_24    = 12'd2730;
  localparam int unsigned C100_SHIFT  = 19;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam logic [13:0] RECIP_7     = 14'd9362;

  typedef enum logic [1:0] {
    UNIT_SEC,
    UNIT_MIN,
    UNIT_HOUR
  } unit_e;

  typedef struct packed {
    logic capture;
    logic start;
    logic div_mul;
    logic div_fix;
    logic walk;
    logic wk_mul;
    logic wk_sum;
    logic wk_mul7;
    logic wk_fix;
    logic flag;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op_div;
    logic op_day;
    logic unit_is_hour;
    logic walk_done;
    logic out_free;
  } status_t;

  function automatic logic is_leap(logic [11:0] y);
    logic cent;
    logic quad;
    cent = 1'b0;
    quad = 1'b0;
    for (int k = 0; k <= 40; k++) begin
      if (y == 12'(k * 100)) begin
        cent = 1'b1;
        if (k % 4 == 0) quad = 1'b1;
      end
    end
    return (y[1:0] == 2'b00) && (!cent || quad);
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                     n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] sak_offset(logic [3:0] m);
    logic [3:0] v;
    case (m)
      4'd1:    v = 4'd0;
      4'd2:    v = 4'd3;
      4'd3:    v = 4'd2;
      4'd4:    v = 4'd5;
      4'd5:    v = 4'd0;
      4'd6:    v = 4'd3;
      4'd7:    v = 4'd5;
      4'd8:    v = 4'd1;
      4'd9:    v = 4'd4;
      4'd10:   v = 4'd6;
      4'd11:   v = 4'd2;
      4'd12:   v = 4'd4;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  // remainder by seven of a value below 42
  function automatic logic [2:0] mod7_small(logic [5:0] x);
    logic [5:0] v;
    v = x;
    for (int i = 0; i < 5; i++) begin
      if (v >= 6'd7) v = v - 6'd7;
    end
    return v[2:0];
  endfunction

endpackage

@@ hdl/cda_in_if.sv @@
// cda_in_if: input channel of the calendar date-time adder
// valid/ready handshake with the operation payload; no dependencies
interface cda_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [15:0] amount;
  logic [11:0]        load_year;
  logic [3:0]         load_month;
  logic [4:0]         load_day;
  logic [4:0]         load_hour;
  logic [5:0]         load_minute;
  logic [5:0]         load_second;

  modport source (
    output valid, op, amount, load_year, load_month, load_day, load_hour,
           load_minute, load_second,
    input  ready
  );
  modport sink (
    input  valid, op, amount, load_year, load_month, load_day, load_hour,
           load_minute, load_second,
    output ready
  );
endinterface

@@ hdl/cda_out_if.sv @@
// cda_out_if: result channel of the calendar date-time adder
// valid/ready handshake with the date, time and flags; no dependencies
interface cda_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic [2:0]  weekday_out;
  logic        summer_time;
  logic        error;

  modport source (
    output valid, year_out, month_out, day_out, hour_out, minute_out,
           second_out, weekday_out, summer_time, error,
    input  ready
  );
  modport sink (
    input  valid, year_out, month_out, day_out, hour_out, minute_out,
           second_out, weekday_out, summer_time, error,
    output ready
  );
endinterface

@@ hdl/calendar_datetime_adder.sv @@
// calendar_datetime_adder: top level, joins the sequencer and the datapath
// depends on cda_pkg, cda_in_if, cda_out_if, cda_ctrl and cda_dp

// Gregorian date-time keeper. Each input beat either loads a date and time
// (checked, rejected with error set), adds a signed count of seconds,
// minutes, hours or days, or, for an unknown op, just reports. Every beat
// returns exactly one output beat with the date and time, the weekday
// (0 Sunday) and the EU summer-time flag reading the clock as UTC. One item
// is in flight at a time: a load or unknown op goes from capture through the
// weekday and summer-time states into the output register, and the next beat
// can be taken once that result is loaded. A seconds/minutes/hours add first
// runs a divide step per unit in the carry chain, and every add then runs the
// month walker, one step per calendar month crossed plus a final step. A
// stalled output adds its stall to the item. The output register lets the
// next beat be taken while a result waits.
module calendar_datetime_adder (
  input logic  clk_i,
  input logic  rst_ni,
  cda_in_if.sink    in_i,
  cda_out_if.source out_o
);

  // command and status between sequencer and datapath
  cda_pkg::cmd_t    cmd;
  cda_pkg::status_t status;

  cda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath holds the calendar state and the output register
  cda_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .op_i          (in_i.op),
    .amount_i      (in_i.amount),
    .load_year_i   (in_i.load_year),
    .load_month_i  (in_i.load_month),
    .load_day_i    (in_i.load_day),
    .load_hour_i   (in_i.load_hour),
    .load_minute_i (in_i.load_minute),
    .load_second_i (in_i.load_second),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .year_out_o    (out_o.year_out),
    .month_out_o   (out_o.month_out),
    .day_out_o     (out_o.day_out),
    .hour_out_o    (out_o.hour_out),
    .minute_out_o  (out_o.minute_out),
    .second_out_o  (out_o.second_out),
    .weekday_out_o (out_o.weekday_out),
    .summer_time_o (out_o.summer_time),
    .error_o       (out_o.error)
  );

endmodule

@@ hdl/cda_ctrl.sv @@
// cda_ctrl: sequencer of the calendar date-time adder
// depends on cda_pkg (cmd_t, status_t)
module cda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cda_pkg::status_t  status_i,
  output cda_pkg::cmd_t     cmd_o
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_START = 11'b00000000010,
    ST_DMUL  = 11'b00000000100,
    ST_DFIX  = 11'b00000001000,
    ST_WALK  = 11'b00000010000,
    ST_WMUL  = 11'b00000100000,
    ST_WSUM  = 11'b00001000000,
    ST_WMUL7 = 11'b00010000000,
    ST_WFIX  = 11'b00100000000,
    ST_FLAG  = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        if (status_i.op_div)      state_d = ST_DMUL;
        else if (status_i.op_day) state_d = ST_WALK;
        else                      state_d = ST_WMUL;
      end
      ST_DMUL: begin
        cmd_o.div_mul = 1'b1;
        state_d       = ST_DFIX;
      end
      ST_DFIX: begin
        cmd_o.div_fix = 1'b1;
        state_d       = status_i.unit_is_hour ? ST_WALK : ST_DMUL;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_done) state_d = ST_WMUL;
      end
      ST_WMUL: begin
        cmd_o.wk_mul = 1'b1;
        state_d      = ST_WSUM;
      end
      ST_WSUM: begin
        cmd_o.wk_sum = 1'b1;
        state_d      = ST_WMUL7;
      end
      ST_WMUL7: begin
        cmd_o.wk_mul7 = 1'b1;
        state_d       = ST_WFIX;
      end
      ST_WFIX: begin
        cmd_o.wk_fix = 1'b1;
        state_d      = ST_FLAG;
      end
      ST_FLAG: begin
        cmd_o.flag = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/cda_dp.sv @@
// cda_dp: datapath of the calendar date-time adder: state, carry divider,
// month walker, weekday and summer-time logic; depends on cda_pkg
module cda_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cda_pkg::cmd_t      cmd_i,
  output cda_pkg::status_t   status_o,
  input  logic [2:0]         op_i,
  input  logic signed [15:0] amount_i,
  input  logic [11:0]        load_year_i,
  input  logic [3:0]         load_month_i,
  input  logic [4:0]         load_day_i,
  input  logic [4:0]         load_hour_i,
  input  logic [5:0]         load_minute_i,
  input  logic [5:0]         load_second_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [11:0]        year_out_o,
  output logic [3:0]         month_out_o,
  output logic [4:0]         day_out_o,
  output logic [4:0]         hour_out_o,
  output logic [5:0]         minute_out_o,
  output logic [5:0]         second_out_o,
  output logic [2:0]         weekday_out_o,
  output logic               summer_time_o,
  output logic               error_o
);

  // captured item
  logic [2:0]         op_q;
  logic signed [15:0] amt_q;
  logic [11:0]        ld_year_q;
  logic [3:0]         ld_month_q;
  logic [4:0]         ld_day_q;
  logic [4:0]         ld_hour_q;
  logic [5:0]         ld_minute_q;
  logic [5:0]         ld_second_q;

  // calendar state
  logic [11:0] cal_year_q;
  logic [3:0]  cal_month_q;
  logic [4:0]  cal_day_q;
  logic [4:0]  cal_hour_q;
  logic [5:0]  cal_minute_q;
  logic [5:0]  cal_second_q;

  // working registers
  cda_pkg::unit_e     unit_q;
  logic signed [17:0] t_q;
  logic               neg_q;
  logic [15:0]        u_q;
  logic [10:0]        q0_q;
  logic [4:0]         hour_n_q;
  logic [5:0]         min_n_q;
  logic [5:0]         sec_n_q;
  logic signed [17:0] d_w_q;
  logic [3:0]         mo_w_q;
  logic [11:0]        y_w_q;
  logic               err_q;
  logic [12:0]        yy_q;
  logic [5:0]         c100_q;
  logic [12:0]        sum_q;
  logic [9:0]         q7_q;
  logic [2:0]         wd_q;
  logic               summer_q;
  logic               out_valid_q;

  // ---- start of an item ----
  logic signed [17:0] amt_ext;
  logic               ld_ok;
  assign amt_ext = $signed({{2{amt_q[15]}}, amt_q});
  assign ld_ok = (ld_month_q >= 4'd1) && (ld_month_q <= cda_pkg::MONTH_DEC) &&
                 (ld_day_q >= 5'd1) &&
                 (ld_day_q <= cda_pkg::month_len(ld_month_q,
                                                 cda_pkg::is_leap(ld_year_q))) &&
                 (ld_hour_q <= 5'd23) && (ld_minute_q <= 6'd59) &&
                 (ld_second_q <= 6'd59);

  // ---- floor division of the carry chain ----
  logic [5:0]         div_d;
  logic [11:0]        div_k;
  logic [15:0]        div_u;
  logic [27:0]        div_prod;
  logic [16:0]        div_r0;
  logic [16:0]        div_r;
  logic [10:0]        div_q;
  logic signed [17:0] carry;
  logic [5:0]         rem;

  always_comb begin
    if (unit_q == cda_pkg::UNIT_HOUR) begin
      div_d = 6'd24;
      div_k = cda_pkg::RECIP_24;
    end else begin
      div_d = 6'd60;
      div_k = cda_pkg::RECIP_60;
    end
  end

  // magnitude of the running sum, one's complement when negative
  assign div_u    = t_q[17] ? 16'(~t_q) : 16'(t_q);
  assign div_prod = 28'(div_u) * 28'(div_k);
  assign div_r0   = {1'b0, u_q} - 17'(q0_q * div_d);

  always_comb begin
    if (div_r0 >= 17'(div_d)) begin
      div_r = div_r0 - 17'(div_d);
      div_q = q0_q + 11'd1;
    end else begin
      div_r = div_r0;
      div_q = q0_q;
    end
    if (neg_q) begin
      carry = -$signed({7'b0, div_q}) - 18'sd1;
      rem   = div_d - 6'd1 - div_r[5:0];
    end else begin
      carry = $signed({7'b0, div_q});
      rem   = div_r[5:0];
    end
  end

  // ---- month walk ----
  logic [4:0]  ml;
  logic [3:0]  pm;
  logic [11:0] py;
  logic [4:0]  pml;
  logic        fwd;
  logic        bwd;
  logic        ovf;
  logic        walk_done;

  assign ml  = cda_pkg::month_len(mo_w_q, cda_pkg::is_leap(y_w_q));
  assign pm  = (mo_w_q == 4'd1) ? cda_pkg::MONTH_DEC : mo_w_q - 4'd1;
  assign py  = (mo_w_q == 4'd1) ? y_w_q - 12'd1 : y_w_q;
  assign pml = cda_pkg::month_len(pm, cda_pkg::is_leap(py));
  assign fwd = d_w_q > $signed({13'b0, ml});
  assign bwd = d_w_q < 18'sd1;
  assign ovf = (fwd && (mo_w_q == cda_pkg::MONTH_DEC) && (y_w_q == cda_pkg::YEAR_MAX)) ||
               (bwd && (mo_w_q == 4'd1) && (y_w_q == 12'd0));
  assign walk_done = ovf || (!fwd && !bwd);

  // ---- weekday and summer time ----
  logic [12:0] yy;
  logic [25:0] c100_prod;
  logic [26:0] q7_prod;
  logic [3:0]  r7;
  logic [2:0]  w31;
  logic [4:0]  lsd;
  logic        after;
  logic        summer;

  assign yy = {1'b0, cal_year_q} + 13'd400 -
              13'((cal_month_q < cda_pkg::MONTH_MAR) ? 1 : 0);
  assign c100_prod = 26'(yy) * 26'(cda_pkg::RECIP_100);
  assign q7_prod   = 27'(sum_q) * 27'(cda_pkg::RECIP_7);
  assign r7 = 4'(sum_q - 13'(q7_q * 4'd7));
  assign w31 = cda_pkg::mod7_small(6'(wd_q) + 6'd31 - {1'b0, cal_day_q});
  assign lsd = 5'd31 - {2'b0, w31};
  assign after = (cal_day_q > lsd) || ((cal_day_q == lsd) && (cal_hour_q != 5'd0));

  always_comb begin
    if ((cal_month_q < cda_pkg::MONTH_MAR) || (cal_month_q > cda_pkg::MONTH_OCT)) begin
      summer = 1'b0;
    end else if ((cal_month_q > cda_pkg::MONTH_MAR) && (cal_month_q < cda_pkg::MONTH_OCT)) begin
      summer = 1'b1;
    end else if (cal_month_q == cda_pkg::MONTH_MAR) begin
      summer = after;
    end else begin
      summer = !after;
    end
  end

  // ---- status ----
  assign status_o.op_div = (op_q == cda_pkg::OP_ADD_SEC) || (op_q == cda_pkg::OP_ADD_MIN) ||
                           (op_q == cda_pkg::OP_ADD_HOUR);
  assign status_o.op_day       = (op_q == cda_pkg::OP_ADD_DAY);
  assign status_o.unit_is_hour = (unit_q == cda_pkg::UNIT_HOUR);
  assign status_o.walk_done    = walk_done;
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= op_i;
      amt_q       <= amount_i;
      ld_year_q   <= load_year_i;
      ld_month_q  <= load_month_i;
      ld_day_q    <= load_day_i;
      ld_hour_q   <= load_hour_i;
      ld_minute_q <= load_minute_i;
      ld_second_q <= load_second_i;
    end
    if (cmd_i.start) begin
      err_q    <= (op_q == cda_pkg::OP_LOAD) && !ld_ok;
      hour_n_q <= cal_hour_q;
      min_n_q  <= cal_minute_q;
      sec_n_q  <= cal_second_q;
      mo_w_q   <= cal_month_q;
      y_w_q    <= cal_year_q;
      d_w_q    <= $signed({13'b0, cal_day_q}) + amt_ext;
      case (op_q)
        cda_pkg::OP_ADD_SEC: begin
          unit_q <= cda_pkg::UNIT_SEC;
          t_q    <= $signed({12'b0, cal_second_q}) + amt_ext;
        end
        cda_pkg::OP_ADD_MIN: begin
          unit_q <= cda_pkg::UNIT_MIN;
          t_q    <= $signed({12'b0, cal_minute_q}) + amt_ext;
        end
        default: begin
          unit_q <= cda_pkg::UNIT_HOUR;
          t_q    <= $signed({13'b0, cal_hour_q}) + amt_ext;
        end
      endcase
    end
    if (cmd_i.div_mul) begin
      neg_q <= t_q[17];
      u_q   <= div_u;
      q0_q  <= 11'(div_prod >> cda_pkg::RECIP_SHIFT);
    end
    if (cmd_i.div_fix) begin
      case (unit_q)
        cda_pkg::UNIT_SEC: begin
          sec_n_q <= rem;
          unit_q  <= cda_pkg::UNIT_MIN;
          t_q     <= $signed({12'b0, cal_minute_q}) + carry;
        end
        cda_pkg::UNIT_MIN: begin
          min_n_q <= rem;
          unit_q  <= cda_pkg::UNIT_HOUR;
          t_q     <= $signed({13'b0, cal_hour_q}) + carry;
        end
        default: begin
          hour_n_q <= rem[4:0];
          d_w_q    <= $signed({13'b0, cal_day_q}) + carry;
        end
      endcase
    end
    if (cmd_i.walk) begin
      if (ovf) begin
        err_q <= 1'b1;
      end else if (fwd) begin
        d_w_q <= d_w_q - $signed({13'b0, ml});
        if (mo_w_q == cda_pkg::MONTH_DEC) begin
          mo_w_q <= 4'd1;
          y_w_q  <= y_w_q + 12'd1;
        end else begin
          mo_w_q <= mo_w_q + 4'd1;
        end
      end else if (bwd) begin
        mo_w_q <= pm;
        y_w_q  <= py;
        d_w_q  <= d_w_q + $signed({13'b0, pml});
      end
    end
    if (cmd_i.wk_mul) begin
      yy_q   <= yy;
      c100_q <= 6'(c100_prod >> cda_pkg::C100_SHIFT);
    end
    if (cmd_i.wk_sum) begin
      sum_q <= yy_q + (yy_q >> 2) - {7'b0, c100_q} + {9'b0, c100_q[5:2]} +
               {9'b0, cda_pkg::sak_offset(cal_month_q)} + {8'b0, cal_day_q};
    end
    if (cmd_i.wk_mul7) begin
      q7_q <= 10'(q7_prod >> cda_pkg::RECIP_SHIFT);
    end
    if (cmd_i.wk_fix) begin
      wd_q <= (r7 >= 4'd7) ? 3'(r7 - 4'd7) : r7[2:0];
    end
    if (cmd_i.flag) begin
      summer_q <= summer;
    end
    if (cmd_i.out_load) begin
      year_out_o    <= cal_year_q;
      month_out_o   <= cal_month_q;
      day_out_o     <= cal_day_q;
      hour_out_o    <= cal_hour_q;
      minute_out_o  <= cal_minute_q;
      second_out_o  <= cal_second_q;
      weekday_out_o <= wd_q;
      summer_time_o <= summer_q;
      error_o       <= err_q;
    end
  end

  // ---- calendar state and output handshake ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_year_q   <= 12'd0;
      cal_month_q  <= 4'd1;
      cal_day_q    <= 5'd1;
      cal_hour_q   <= 5'd0;
      cal_minute_q <= 6'd0;
      cal_second_q <= 6'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.start && (op_q == cda_pkg::OP_LOAD) && ld_ok) begin
        cal_year_q   <= ld_year_q;
        cal_month_q  <= ld_month_q;
        cal_day_q    <= ld_day_q;
        cal_hour_q   <= ld_hour_q;
        cal_minute_q <= ld_minute_q;
        cal_second_q <= ld_second_q;
      end
      if (cmd_i.walk && walk_done && !ovf) begin
        cal_year_q   <= y_w_q;
        cal_month_q  <= mo_w_q;
        cal_day_q    <= d_w_q[4:0];
        cal_hour_q   <= hour_n_q;
        cal_minute_q <= min_n_q;
        cal_second_q <= sec_n_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
